// ===== src/cbrt_pkg.sv =====
// ----------------------------------------------------------------------------
// cbrt_pkg: shared types and constants of the capture buffer ring tracker
// Holds the request/response format of the shared arithmetic unit, the
// register indexes, the result status codes and the fixed field widths.
// ----------------------------------------------------------------------------
package cbrt_pkg;

    localparam int MAX_BUFFERS_DEF = 8;
    localparam int SLOT_VEC_W      = 8;   // done bits padded to the widest ring
    localparam int ALU_W           = 32;
    localparam int QUO_W           = 20;  // 1000000 fits in 20 bits
    localparam logic [QUO_W-1:0] US_PER_SEC = 20'd1000000;

    // Configuration register indexes.
    localparam logic [1:0] REG_STREAMING_ON = 2'd0;
    localparam logic [1:0] REG_RING_SIZE    = 2'd1;
    localparam logic [1:0] REG_FPS          = 2'd2;
    localparam logic [1:0] REG_FORWARD_MODE = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_NOT_STREAMING = 2'd0;
    localparam logic [1:0] ST_NO_DONE       = 2'd1;
    localparam logic [1:0] ST_BAD_ORDER     = 2'd2;
    localparam logic [1:0] ST_BUF_DONE      = 2'd3;

    // Error masks on the interrupt status word.
    localparam logic [31:0] ERR_PIXEL_MASK = 32'h0800_0200;
    localparam logic [31:0] ERR_LINE_MASK  = 32'h4000_0200;
    localparam logic [31:0] ERR_VSYNC_MASK = 32'h2000_0200;
    localparam logic [31:0] ERR_NPL_MASK   = 32'h0000_0800;
    localparam logic [31:0] ERR_LBUF_MASK  = 32'h0000_0400;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             ge;   // a >= b, valid for subtraction
    } t_alu_rsp;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  error_flags;
        logic        halt_request;
        logic [2:0]  buffer_index;
        logic [31:0] done_stamp;
        logic        overwritten;
        logic        wake_post;
        logic        last;
    } t_result;

endpackage

// ===== src/cbrt_alu.sv =====
// ----------------------------------------------------------------------------
// cbrt_alu: shared add/subtract unit
// One 32-bit adder with carry out, used by the sequencer for the modulo
// reductions, the period division steps and the timestamp arithmetic.
// ----------------------------------------------------------------------------
module cbrt_alu (
    input  cbrt_pkg::t_alu_req i_req,
    output cbrt_pkg::t_alu_rsp o_rsp
);
    import cbrt_pkg::*;

    logic [ALU_W:0] w_sum;

    assign w_sum = {1'b0, i_req.a} + {1'b0, (i_req.sub ? ~i_req.b : i_req.b)}
                 + {{ALU_W{1'b0}}, i_req.sub};
    assign o_rsp.res = w_sum[ALU_W-1:0];
    assign o_rsp.ge  = w_sum[ALU_W];

endmodule

// ===== src/capture_buffer_ring_tracker_core.sv =====
// ----------------------------------------------------------------------------
// capture_buffer_ring_tracker_core: capture interrupt ring tracker
// Decodes capture interrupt status words into per-buffer completion items or a single status item.
// ----------------------------------------------------------------------------
// Usage: program the registers over the cfg channel (index 0 streaming_on,
// 1 ring_size, 2 frames per second, 3 forward_mode) while the block is idle.
// Each input item on s_axis carries an interrupt status word, a timestamp and
// the free buffer count. The block answers with one or more result items on
// m_axis; tuser holds the status code and tlast marks the final item of an
// input. A not-streaming or no-buffer-done input gives one result item. An
// order mismatch runs the ring position reduction, the order walk and the
// resync reduction, then gives one result item. A buffer-done input runs
// the ring position reduction, an order walk over the done slots, a
// restoring division for the frame period, the timestamp back-dating and
// the emission of one item per done bit, all on one shared 32-bit adder.
// s_axis_tready is high only while the sequencer is idle. A stalled receiver
// holds the output register and the sequencer waits on it; the next input is
// taken as soon as the final result sits in the output register. Reset
// returns the registers to their defaults and the ring position to zero.
// ----------------------------------------------------------------------------
module capture_buffer_ring_tracker_core #(
    parameter int MAX_BUFFERS = cbrt_pkg::MAX_BUFFERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // Input items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] irq_status, [63:32] timestamp_us, [67:64] free_buffers, [71:68] zero
    input  logic [71:0] s_axis_tdata,
    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] error_flags, [5] halt_request, [8:6] buffer_index,
    // [40:9] done_stamp, [41] overwritten, [42] wake_post, [47:43] zero
    output logic [47:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import cbrt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SINGLE = 3'd1;
    localparam logic [2:0] S_MOD    = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_RESYNC = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_BASE   = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    localparam logic [3:0] TOT_MAX = 4'(MAX_BUFFERS);

    // Configuration registers.
    logic        r_stream;
    logic [3:0]  r_ring_size;
    logic [7:0]  r_fps;
    logic        r_fwd;

    // Sequencer state.
    logic [2:0]        r_state,  n_state;
    logic [2:0]        r_pos,    n_pos;
    logic [SLOT_VEC_W-1:0] r_done, n_done;
    logic [4:0]        r_err,    n_err;
    logic [31:0]       r_stamp,  n_stamp;
    logic [3:0]        r_free,   n_free;
    logic [3:0]        r_count,  n_count;
    logic [3:0]        r_idx,    n_idx;
    logic [3:0]        r_tot,    n_tot;
    logic [2:0]        r_cur,    n_cur;
    logic [2:0]        r_slot,   n_slot;
    logic [7:0]        r_div,    n_div;
    logic [7:0]        r_rem,    n_rem;
    logic [QUO_W-1:0]  r_quo,    n_quo;
    logic [4:0]        r_bits,   n_bits;
    logic              r_deliv,  n_deliv;
    logic [1:0]        r_status, n_status;

    // Output register.
    logic        r_out_valid, n_out_valid;
    t_result     r_out,       n_out;

    t_alu_req w_req;
    t_alu_rsp w_rsp;

    logic [31:0]           w_irq;
    logic [SLOT_VEC_W-1:0] w_done;
    logic [4:0]            w_err;
    logic [3:0]            w_pop;
    logic [3:0]            w_tot;
    logic                  w_out_free;
    logic [8:0]            w_rem_sh;
    logic [2:0]            w_cur_inc;
    logic [2:0]            w_slot_inc;
    logic                  w_last;
    logic                  w_ow;

    function automatic logic [2:0] resync_index(input logic [SLOT_VEC_W-1:0] done);
        logic       seen;
        logic       found;
        logic [2:0] idx;
        seen  = 1'b0;
        found = 1'b0;
        idx   = 3'd0;
        for (int i = 0; i < MAX_BUFFERS; i++) begin
            if (done[i]) begin
                seen = 1'b1;
            end else if (seen && !found) begin
                found = 1'b1;
                idx   = 3'(i);
            end
        end
        return idx;
    endfunction

    cbrt_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {5'd0, r_out.wake_post, r_out.overwritten, r_out.done_stamp,
                            r_out.buffer_index, r_out.halt_request, r_out.error_flags};

    assign w_irq      = s_axis_tdata[31:0];
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_rem_sh   = {r_rem, r_quo[QUO_W-1]};
    assign w_cur_inc  = ({1'b0, r_cur} + 4'd1 == r_tot) ? 3'd0 : r_cur + 3'd1;
    assign w_slot_inc = ({1'b0, r_slot} + 4'd1 == r_tot) ? 3'd0 : r_slot + 3'd1;
    assign w_last     = (r_idx + 4'd1 == r_count);
    assign w_ow       = (r_free == 4'd0);

    always_comb begin
        w_done = '0;
        for (int i = 0; i < MAX_BUFFERS; i++) begin
            w_done[i] = w_irq[i+1];
        end
        w_pop = '0;
        for (int i = 0; i < SLOT_VEC_W; i++) begin
            w_pop = w_pop + {3'd0, w_done[i]};
        end
        w_err[0] = |(w_irq & ERR_PIXEL_MASK);
        w_err[1] = |(w_irq & ERR_LINE_MASK);
        w_err[2] = |(w_irq & ERR_VSYNC_MASK);
        w_err[3] = |(w_irq & ERR_NPL_MASK);
        w_err[4] = |(w_irq & ERR_LBUF_MASK);
        if (r_ring_size < 4'd2) begin
            w_tot = 4'd2;
        end else if (r_ring_size > TOT_MAX) begin
            w_tot = TOT_MAX;
        end else begin
            w_tot = r_ring_size;
        end
    end

    // Operand selection for the shared adder.
    always_comb begin
        w_req = '0;
        unique case (r_state)
            S_MOD, S_RESYNC: begin
                w_req.a   = {29'd0, r_cur};
                w_req.b   = {28'd0, r_tot};
                w_req.sub = 1'b1;
            end
            S_DIV: begin
                w_req.a   = {23'd0, w_rem_sh};
                w_req.b   = {24'd0, r_div};
                w_req.sub = 1'b1;
            end
            S_BASE: begin
                w_req.a   = r_stamp;
                w_req.b   = {{(ALU_W-QUO_W){1'b0}}, r_quo};
                w_req.sub = 1'b1;
            end
            S_EMIT: begin
                w_req.a   = r_stamp;
                w_req.b   = {{(ALU_W-QUO_W){1'b0}}, r_quo};
                w_req.sub = 1'b0;
            end
            default: begin
                w_req = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_done      = r_done;
        n_err       = r_err;
        n_stamp     = r_stamp;
        n_free      = r_free;
        n_count     = r_count;
        n_idx       = r_idx;
        n_tot       = r_tot;
        n_cur       = r_cur;
        n_slot      = r_slot;
        n_div       = r_div;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_bits      = r_bits;
        n_deliv     = r_deliv;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && !m_axis_tready;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_done  = w_done;
                    n_err   = r_stream ? w_err : 5'd0;
                    n_stamp = s_axis_tdata[63:32];
                    n_free  = s_axis_tdata[67:64];
                    n_count = w_pop;
                    n_tot   = w_tot;
                    n_cur   = r_pos;
                    n_div   = (r_fps == 8'd0) ? 8'd1 : r_fps;
                    n_deliv = 1'b0;
                    if (!r_stream) begin
                        n_status = ST_NOT_STREAMING;
                        n_state  = S_SINGLE;
                    end else if (w_pop == 4'd0) begin
                        n_status = ST_NO_DONE;
                        n_state  = S_SINGLE;
                    end else begin
                        n_state  = S_MOD;
                    end
                end
            end
            S_SINGLE: begin
                if (w_out_free) begin
                    n_out              = '0;
                    n_out.status       = r_status;
                    n_out.error_flags  = r_err;
                    n_out.halt_request = |r_err;
                    n_out.last         = 1'b1;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_MOD: begin
                // Bring the start position below the ring size.
                if (w_rsp.ge) begin
                    n_cur = w_rsp.res[2:0];
                end else begin
                    n_slot  = r_cur;
                    n_idx   = 4'd0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_idx == r_count) begin
                    // The walk ends on the slot after the last done buffer.
                    n_pos   = r_cur;
                    n_rem   = 8'd0;
                    n_quo   = US_PER_SEC;
                    n_bits  = 5'd0;
                    n_state = S_DIV;
                end else if (!r_done[r_cur]) begin
                    n_cur    = resync_index(r_done);
                    n_status = ST_BAD_ORDER;
                    n_state  = S_RESYNC;
                end else begin
                    n_cur = w_cur_inc;
                    n_idx = r_idx + 4'd1;
                end
            end
            S_RESYNC: begin
                if (w_rsp.ge) begin
                    n_cur = w_rsp.res[2:0];
                end else begin
                    n_pos   = r_cur;
                    n_state = S_SINGLE;
                end
            end
            S_DIV: begin
                // Restoring division, one quotient bit per cycle.
                n_rem  = w_rsp.ge ? w_rsp.res[7:0] : w_rem_sh[7:0];
                n_quo  = {r_quo[QUO_W-2:0], w_rsp.ge};
                n_bits = r_bits + 5'd1;
                if (r_bits == 5'(QUO_W - 1)) begin
                    n_idx   = 4'd1;
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                // Back-date the oldest buffer by period * (count - 1).
                if (r_idx == r_count) begin
                    n_idx   = 4'd0;
                    n_state = S_EMIT;
                end else begin
                    n_stamp = w_rsp.res;
                    n_idx   = r_idx + 4'd1;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out.status       = ST_BUF_DONE;
                    n_out.error_flags  = r_err;
                    n_out.halt_request = |r_err;
                    n_out.buffer_index = r_slot;
                    n_out.done_stamp   = w_ow ? 32'd0 : r_stamp;
                    n_out.overwritten  = w_ow;
                    n_out.wake_post    = w_last && r_fwd && (r_deliv || !w_ow);
                    n_out.last         = w_last;
                    n_out_valid        = 1'b1;
                    n_deliv            = r_deliv || !w_ow;
                    n_free             = w_ow ? r_free : r_free - 4'd1;
                    n_stamp            = w_rsp.res;
                    n_slot             = w_slot_inc;
                    n_idx              = r_idx + 4'd1;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream     <= 1'b0;
            r_ring_size  <= 4'd2;
            r_fps        <= 8'd30;
            r_fwd        <= 1'b0;
            r_state      <= S_IDLE;
            r_pos        <= 3'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_STREAMING_ON: r_stream     <= i_cfg_data[0];
                    REG_RING_SIZE:    r_ring_size  <= i_cfg_data[3:0];
                    REG_FPS:          r_fps        <= i_cfg_data;
                    REG_FORWARD_MODE: r_fwd        <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_done   <= n_done;
        r_err    <= n_err;
        r_stamp  <= n_stamp;
        r_free   <= n_free;
        r_count  <= n_count;
        r_idx    <= n_idx;
        r_tot    <= n_tot;
        r_cur    <= n_cur;
        r_slot   <= n_slot;
        r_div    <= n_div;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_bits   <= n_bits;
        r_deliv  <= n_deliv;
        r_status <= n_status;
        r_out    <= n_out;
    end

    // Only buffer-done items can be followed by more items of the same input.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_BUF_DONE) |-> m_axis_tlast)
        else $error("single-result status without last");

    // The halt request always mirrors the error flags.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[5] == (m_axis_tdata[4:0] != 5'd0)))
        else $error("halt request does not match error flags");

    // The emission counter never runs past the number of done buffers.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_idx < r_count))
        else $error("emission index overran done count");

    // An overwritten buffer carries no timestamp.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[41]) |-> (m_axis_tdata[40:9] == 32'd0))
        else $error("overwritten buffer with nonzero stamp");

endmodule
